### hdl/tftp_pkg.sv
// Shared types and constants for the TFTP server transfer control.
// Holds the request and result structs, the phase encoding and the protocol codes.
// No dependencies.
`default_nettype none

package tftp_pkg;

  // Field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned OP_W    = 16;
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned ECODE_W = 3;
  localparam int unsigned OUTC_W  = 2;
  localparam int unsigned RETRY_W = 4;

  // Largest DATA payload of one block
  localparam int unsigned BLOCK_BYTES = 512;

  // Retry limit after reset
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = 4'd5;

  // Event kinds
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PACKET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  // TFTP opcodes
  localparam logic [OP_W-1:0] OP_RRQ  = 16'd1;
  localparam logic [OP_W-1:0] OP_WRQ  = 16'd2;
  localparam logic [OP_W-1:0] OP_DATA = 16'd3;
  localparam logic [OP_W-1:0] OP_ACK  = 16'd4;
  localparam logic [OP_W-1:0] OP_ERR  = 16'd5;

  // Actions
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DATA    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RE_DATA = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ACK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RE_ACK  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ERR     = 3'd5;

  // TFTP error codes
  localparam logic [ECODE_W-1:0] ERR_GENERIC   = 3'd0;
  localparam logic [ECODE_W-1:0] ERR_NOT_FOUND = 3'd1;
  localparam logic [ECODE_W-1:0] ERR_EXISTS    = 3'd6;

  // Outcomes
  localparam logic [OUTC_W-1:0] OUTC_NONE  = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_OK    = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_ERROR = 2'd2;

  // Transfer phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE          = 5'b00001,
    PH_WAIT_ACK      = 5'b00010,
    PH_WAIT_LAST_ACK = 5'b00100,
    PH_WAIT_FIRST_P  = 5'b01000,
    PH_WAIT_NEXT_P   = 5'b10000
  } phase_t;

  // One event request
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [OP_W-1:0]   opcode;
    logic [BLK_W-1:0]  block_number;
    logic [LEN_W-1:0]  payload_length;
    logic              port_matches;
    logic              file_exists;
    logic              file_open_ok;
    logic [LEN_W-1:0]  next_block_length;
  } item_t;

  // One result
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BLK_W-1:0]   packet_block;
    logic [LEN_W-1:0]   packet_length;
    logic [ECODE_W-1:0] error_code;
    logic               store_block;
    logic               close_file;
    logic [OUTC_W-1:0]  outcome;
  } result_t;

  // Handshake between the control stage and the result register
  typedef struct packed {
    logic advance;  // control stage hands its result over this cycle
  } stage_hs_t;

endpackage

`default_nettype wire

### hdl/tftp_in_reg.sv
// Input register of the TFTP transfer control: captures one event request.
// Depends on tftp_pkg.
`default_nettype none

module tftp_in_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire tftp_pkg::item_t     in_item,
  input  wire tftp_pkg::stage_hs_t hs,
  output logic                     item_valid,
  output tftp_pkg::item_t          item
);

  logic accept;

  // Stall only while a held request cannot move on
  assign in_stall = item_valid && !hs.advance;
  assign accept   = in_valid && !in_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (hs.advance) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### hdl/tftp_ctrl.sv
// Transfer control of the TFTP server: phase, block counter, retries and the
// per-event decision logic. Depends on tftp_pkg.
`default_nettype none

module tftp_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [tftp_pkg::RETRY_W-1:0]        cfg_wr_data,
  input  wire logic                                item_valid,
  input  wire tftp_pkg::item_t                     item,
  input  wire logic                                load_ok,
  output tftp_pkg::stage_hs_t                      hs,
  output tftp_pkg::result_t                        result
);

  tftp_pkg::phase_t                   phase, phase_next;
  logic [tftp_pkg::BLK_W-1:0]         block_counter, block_counter_next;
  logic [tftp_pkg::RETRY_W-1:0]       retry_count, retry_count_next;
  logic [tftp_pkg::LEN_W-1:0]         last_length, last_length_next;
  logic [tftp_pkg::RETRY_W-1:0]       max_retries;

  logic                               reading, writing, file_open;
  logic [tftp_pkg::LEN_W-1:0]         nlen;
  logic [tftp_pkg::BLK_W-1:0]         blk_inc;
  logic [tftp_pkg::BLK_W-1:0]         blk_dec;
  logic                               can_retry;
  logic                               full_block;
  logic                               send_short;

  assign hs.advance = item_valid && load_ok;

  // Phase groups
  assign reading   = (phase == tftp_pkg::PH_WAIT_ACK) || (phase == tftp_pkg::PH_WAIT_LAST_ACK);
  assign writing   = (phase == tftp_pkg::PH_WAIT_FIRST_P) || (phase == tftp_pkg::PH_WAIT_NEXT_P);
  assign file_open = reading || (phase == tftp_pkg::PH_WAIT_NEXT_P);

  // Clip the length the file offers to one block
  assign nlen = (32'(item.next_block_length) > tftp_pkg::BLOCK_BYTES)
              ? tftp_pkg::LEN_W'(tftp_pkg::BLOCK_BYTES) : item.next_block_length;
  assign send_short = 32'(nlen) < tftp_pkg::BLOCK_BYTES;
  assign full_block = 32'(item.payload_length) == tftp_pkg::BLOCK_BYTES;

  // Block numbers wrap from the top back to one
  assign blk_inc   = (block_counter == '1) ? tftp_pkg::BLK_W'(1) : block_counter + 1'b1;
  assign blk_dec   = block_counter - 1'b1;
  assign can_retry = retry_count < max_retries;

  // Decide the result and next state for the held event
  always_comb begin
    phase_next         = phase;
    block_counter_next = block_counter;
    retry_count_next   = retry_count;
    last_length_next   = last_length;
    result             = '0;

    case (item.func)
      tftp_pkg::FUNC_REQUEST: begin
        if (phase == tftp_pkg::PH_IDLE) begin
          if (item.opcode == tftp_pkg::OP_RRQ) begin
            if (!item.file_exists) begin
              result.action     = tftp_pkg::ACT_ERR;
              result.error_code = tftp_pkg::ERR_NOT_FOUND;
              result.outcome    = tftp_pkg::OUTC_ERROR;
            end else if (!item.file_open_ok) begin
              result.action     = tftp_pkg::ACT_ERR;
              result.error_code = tftp_pkg::ERR_GENERIC;
              result.outcome    = tftp_pkg::OUTC_ERROR;
            end else begin
              // Send the first block
              block_counter_next   = tftp_pkg::BLK_W'(1);
              last_length_next     = nlen;
              retry_count_next     = '0;
              result.action        = tftp_pkg::ACT_DATA;
              result.packet_block  = tftp_pkg::BLK_W'(1);
              result.packet_length = nlen;
              phase_next = send_short ? tftp_pkg::PH_WAIT_LAST_ACK : tftp_pkg::PH_WAIT_ACK;
            end
          end else if (item.opcode == tftp_pkg::OP_WRQ) begin
            block_counter_next  = tftp_pkg::BLK_W'(1);
            retry_count_next    = '0;
            result.action       = tftp_pkg::ACT_ACK;
            result.packet_block = '0;
            phase_next          = tftp_pkg::PH_WAIT_FIRST_P;
          end else begin
            result.outcome = tftp_pkg::OUTC_ERROR;
          end
        end
      end

      tftp_pkg::FUNC_TIMEOUT: begin
        if (reading || writing) begin
          if (can_retry) begin
            retry_count_next = retry_count + 1'b1;
            if (reading) begin
              result.action        = tftp_pkg::ACT_RE_DATA;
              result.packet_block  = block_counter;
              result.packet_length = last_length;
            end else begin
              result.action       = tftp_pkg::ACT_RE_ACK;
              result.packet_block = blk_dec;
            end
          end else begin
            result.close_file = file_open;
            result.outcome    = tftp_pkg::OUTC_ERROR;
            phase_next        = tftp_pkg::PH_IDLE;
          end
        end
      end

      tftp_pkg::FUNC_PACKET: begin
        if (reading || writing) begin
          if (!item.port_matches) begin
            // Foreign sender: answer with an error, keep the transfer
            result.action     = tftp_pkg::ACT_ERR;
            result.error_code = tftp_pkg::ERR_GENERIC;
          end else if (item.opcode == tftp_pkg::OP_ERR) begin
            result.close_file = file_open;
            result.outcome    = tftp_pkg::OUTC_ERROR;
            phase_next        = tftp_pkg::PH_IDLE;
          end else if (reading) begin
            if (item.opcode == tftp_pkg::OP_ACK && item.block_number == block_counter) begin
              if (phase == tftp_pkg::PH_WAIT_LAST_ACK) begin
                result.close_file = 1'b1;
                result.outcome    = tftp_pkg::OUTC_OK;
                phase_next        = tftp_pkg::PH_IDLE;
              end else begin
                // Advance to the next block
                block_counter_next   = blk_inc;
                last_length_next     = nlen;
                retry_count_next     = '0;
                result.action        = tftp_pkg::ACT_DATA;
                result.packet_block  = blk_inc;
                result.packet_length = nlen;
                phase_next = send_short ? tftp_pkg::PH_WAIT_LAST_ACK : tftp_pkg::PH_WAIT_ACK;
              end
            end
          end else if (item.opcode == tftp_pkg::OP_DATA) begin
            if (item.block_number != block_counter) begin
              if (can_retry) begin
                retry_count_next    = retry_count + 1'b1;
                result.action       = tftp_pkg::ACT_RE_ACK;
                result.packet_block = blk_dec;
              end else begin
                result.close_file = file_open;
                result.outcome    = tftp_pkg::OUTC_ERROR;
                phase_next        = tftp_pkg::PH_IDLE;
              end
            end else if (phase == tftp_pkg::PH_WAIT_FIRST_P && item.file_exists) begin
              result.action     = tftp_pkg::ACT_ERR;
              result.error_code = tftp_pkg::ERR_EXISTS;
              result.outcome    = tftp_pkg::OUTC_ERROR;
              phase_next        = tftp_pkg::PH_IDLE;
            end else if (phase == tftp_pkg::PH_WAIT_FIRST_P && !item.file_open_ok) begin
              result.action     = tftp_pkg::ACT_ERR;
              result.error_code = tftp_pkg::ERR_GENERIC;
              result.outcome    = tftp_pkg::OUTC_ERROR;
              phase_next        = tftp_pkg::PH_IDLE;
            end else begin
              // Acknowledge and store the block
              result.action       = tftp_pkg::ACT_ACK;
              result.packet_block = item.block_number;
              result.store_block  = 1'b1;
              block_counter_next  = blk_inc;
              retry_count_next    = '0;
              if (full_block) begin
                phase_next = tftp_pkg::PH_WAIT_NEXT_P;
              end else begin
                result.close_file = 1'b1;
                result.outcome    = tftp_pkg::OUTC_OK;
                phase_next        = tftp_pkg::PH_IDLE;
              end
            end
          end
        end
      end

      default: begin
        // Unused event code: no change
      end
    endcase
  end

  // Update transfer state when the result is handed over
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tftp_pkg::PH_IDLE;
      block_counter <= '0;
      retry_count   <= '0;
      last_length   <= '0;
    end else if (hs.advance) begin
      phase         <= phase_next;
      block_counter <= block_counter_next;
      retry_count   <= retry_count_next;
      last_length   <= last_length_next;
    end
  end

  // Retry limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries <= tftp_pkg::MAX_RETRIES_RST;
    end else if (cfg_wr_en) begin
      max_retries <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

### hdl/tftp_out_reg.sv
// Result register of the TFTP transfer control: holds one result until taken.
// Depends on tftp_pkg.
`default_nettype none

module tftp_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tftp_pkg::stage_hs_t hs,
  input  wire tftp_pkg::result_t   result,
  output logic                     load_ok,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output tftp_pkg::result_t        out_result
);

  // Free when empty or when the held result leaves this cycle
  assign load_ok = !out_valid || !out_stall;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hs.advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture result
  always_ff @(posedge clk) begin
    if (hs.advance) begin
      out_result <= result;
    end
  end

endmodule

`default_nettype wire

### hdl/tftp_server_transfer_fsm.sv
// TFTP server transfer control, top level. An accepted request reaches the output
// through the input register, then the result register. One request per cycle
// while out_stall is low; the phase and counters update in the cycle
// a request moves into the result register. Reset (rst, synchronous) empties both
// registers, sets the phase to idle, clears the counters, retry limit to 5.
// Depends on tftp_pkg, tftp_in_reg, tftp_ctrl and tftp_out_reg.
`default_nettype none

module tftp_server_transfer_fsm (
  input  wire logic        clk,
  input  wire logic        rst,
  // Retry limit register
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  // Event requests
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [15:0] opcode,
  input  wire logic [15:0] block_number,
  input  wire logic [9:0]  payload_length,
  input  wire logic        port_matches,
  input  wire logic        file_exists,
  input  wire logic        file_open_ok,
  input  wire logic [9:0]  next_block_length,
  // Results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       action,
  output logic [15:0]      packet_block,
  output logic [9:0]       packet_length,
  output logic [2:0]       error_code,
  output logic             store_block,
  output logic             close_file,
  output logic [1:0]       outcome
);

  tftp_pkg::item_t     in_item;
  tftp_pkg::item_t     item;
  logic                item_valid;
  tftp_pkg::stage_hs_t hs;
  tftp_pkg::result_t   result;
  tftp_pkg::result_t   out_result;
  logic                load_ok;

  // Gather the request fields
  always_comb begin
    in_item.func              = func;
    in_item.opcode            = opcode;
    in_item.block_number      = block_number;
    in_item.payload_length    = payload_length;
    in_item.port_matches      = port_matches;
    in_item.file_exists       = file_exists;
    in_item.file_open_ok      = file_open_ok;
    in_item.next_block_length = next_block_length;
  end

  tftp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .hs         (hs),
    .item_valid (item_valid),
    .item       (item)
  );

  tftp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .load_ok     (load_ok),
    .hs          (hs),
    .result      (result)
  );

  tftp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .hs         (hs),
    .result     (result),
    .load_ok    (load_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  // Spread the result onto its ports
  assign action        = out_result.action;
  assign packet_block  = out_result.packet_block;
  assign packet_length = out_result.packet_length;
  assign error_code    = out_result.error_code;
  assign store_block   = out_result.store_block;
  assign close_file    = out_result.close_file;
  assign outcome       = out_result.outcome;

endmodule

`default_nettype wire
